@@ sv/cna_pkg.sv @@
// Shared operation codes and side-band word type for the complex number ALU.
package cna_pkg;

  localparam logic [3:0] KIND_ADD = 4'd0;
  localparam logic [3:0] KIND_SUB = 4'd1;
  localparam logic [3:0] KIND_MUL = 4'd2;
  localparam logic [3:0] KIND_DIV = 4'd3;
  localparam logic [3:0] KIND_EQ  = 4'd4;
  localparam logic [3:0] KIND_NE  = 4'd5;
  localparam logic [3:0] KIND_GT  = 4'd6;
  localparam logic [3:0] KIND_LE  = 4'd7;
  localparam logic [3:0] KIND_LT  = 4'd8;
  localparam logic [3:0] KIND_GE  = 4'd9;

  // Everything about a word that is settled before the divider chain.
  typedef struct packed {
    logic [31:0] res_real;
    logic [31:0] res_imag;
    logic        test_true;
    logic        overflow;
    logic        divide_by_zero;
    logic        is_div;
  } side_t;

endpackage

@@ sv/cna_div_cell.sv @@
// One restoring-division cell: settles one quotient bit for both lanes.
module cna_div_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int BIT_IDX    = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  cna_pkg::side_t                    side_i,
  input  logic [2*DATA_WIDTH-1:0]           den_i,
  input  logic [1:0][2*DATA_WIDTH-1:0]      num_i,
  input  logic [1:0]                        neg_i,
  input  logic [1:0][2*DATA_WIDTH-1:0]      rem_i,
  input  logic [1:0][DATA_WIDTH-1:0]        quo_i,
  input  logic [1:0]                        stk_i,
  output logic                              valid_o,
  output cna_pkg::side_t                    side_o,
  output logic [2*DATA_WIDTH-1:0]           den_o,
  output logic [1:0][2*DATA_WIDTH-1:0]      num_o,
  output logic [1:0]                        neg_o,
  output logic [1:0][2*DATA_WIDTH-1:0]      rem_o,
  output logic [1:0][DATA_WIDTH-1:0]        quo_o,
  output logic [1:0]                        stk_o
);
  import cna_pkg::*;

  localparam int PW     = 2 * DATA_WIDTH;
  localparam bit HAS_NB = (BIT_IDX >= FRAC_BITS);
  localparam int NB_POS = HAS_NB ? (BIT_IDX - FRAC_BITS) : 0;

  logic                  valid_q;
  side_t                 side_q;
  logic [PW-1:0]         den_q;
  logic [1:0][PW-1:0]    num_q;
  logic [1:0]            neg_q;
  logic [1:0][PW-1:0]    rem_q, rem_d;
  logic [1:0][DATA_WIDTH-1:0] quo_q, quo_d;
  logic [1:0]            stk_q, stk_d;

  always_comb begin
    logic [PW-1:0] shifted;
    logic          nb;
    logic          ge;
    rem_d = '0;
    quo_d = '0;
    stk_d = '0;
    for (int l = 0; l < 2; l++) begin
      nb      = HAS_NB ? num_i[l][NB_POS] : 1'b0;
      // remainder stays below the divisor, so its top bit is clear
      shifted = {rem_i[l][PW-2:0], nb};
      ge      = (shifted >= den_i);
      rem_d[l] = ge ? (shifted - den_i) : shifted;
      quo_d[l] = {quo_i[l][DATA_WIDTH-2:0], ge};
      stk_d[l] = stk_i[l] | quo_i[l][DATA_WIDTH-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      den_q  <= den_i;
      num_q  <= num_i;
      neg_q  <= neg_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      stk_q  <= stk_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign den_o   = den_q;
  assign num_o   = num_q;
  assign neg_o   = neg_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign stk_o   = stk_q;

endmodule

@@ sv/cna_front.sv @@
// Front pipeline: operand capture, products, sums and the non-divide results.
module cna_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [3:0]                        kind_i,
  input  logic signed [31:0]                a_real_i,
  input  logic signed [31:0]                a_imag_i,
  input  logic signed [31:0]                b_real_i,
  input  logic signed [31:0]                b_imag_i,
  output logic                              valid_o,
  output cna_pkg::side_t                    side_o,
  output logic [2*DATA_WIDTH-1:0]           den_o,
  output logic [1:0][2*DATA_WIDTH-1:0]      num_o,
  output logic [1:0]                        neg_o
);
  import cna_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam logic signed [PW:0] MAX_W = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW:0] MIN_W = {{(PW-DW+2){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MAX_D = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_D = {1'b1, {(DW-1){1'b0}}};

  // stage 0: operand capture
  logic                 v0_q;
  logic [3:0]           k0_q;
  logic signed [DW-1:0] ar0_q, ai0_q, br0_q, bi0_q;
  logic                 en0;

  assign en0        = en_i | ~v0_q;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      k0_q  <= kind_i;
      ar0_q <= a_real_i[DW-1:0];
      ai0_q <= a_imag_i[DW-1:0];
      br0_q <= b_real_i[DW-1:0];
      bi0_q <= b_imag_i[DW-1:0];
    end
  end

  // stage 1: eight products
  logic                 v1_q;
  logic [3:0]           k1_q;
  logic signed [DW-1:0] ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [PW-1:0] p_arbr_q, p_aibi_q, p_aibr_q, p_arbi_q;
  logic signed [PW-1:0] p_arar_q, p_aiai_q, p_brbr_q, p_bibi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k1_q     <= k0_q;
      ar1_q    <= ar0_q;
      ai1_q    <= ai0_q;
      br1_q    <= br0_q;
      bi1_q    <= bi0_q;
      p_arbr_q <= PW'(ar0_q) * PW'(br0_q);
      p_aibi_q <= PW'(ai0_q) * PW'(bi0_q);
      p_aibr_q <= PW'(ai0_q) * PW'(br0_q);
      p_arbi_q <= PW'(ar0_q) * PW'(bi0_q);
      p_arar_q <= PW'(ar0_q) * PW'(ar0_q);
      p_aiai_q <= PW'(ai0_q) * PW'(ai0_q);
      p_brbr_q <= PW'(br0_q) * PW'(br0_q);
      p_bibi_q <= PW'(bi0_q) * PW'(bi0_q);
    end
  end

  // stage 2: cross sums, squared magnitudes, add and subtract
  logic                 v2_q;
  logic [3:0]           k2_q;
  logic signed [PW:0]   mr_q, mi_q, dr_q, di_q;
  logic [PW-1:0]        ma_q, mb_q;
  logic signed [DW:0]   sr_q, si_q;
  logic                 eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k2_q <= k1_q;
      mr_q <= (PW+1)'(p_arbr_q) - (PW+1)'(p_aibi_q);
      mi_q <= (PW+1)'(p_aibr_q) + (PW+1)'(p_arbi_q);
      dr_q <= (PW+1)'(p_arbr_q) + (PW+1)'(p_aibi_q);
      di_q <= (PW+1)'(p_aibr_q) - (PW+1)'(p_arbi_q);
      ma_q <= PW'(p_arar_q) + PW'(p_aiai_q);
      mb_q <= PW'(p_brbr_q) + PW'(p_bibi_q);
      eq_q <= (ar1_q == br1_q) && (ai1_q == bi1_q);
      if (k1_q == KIND_SUB) begin
        sr_q <= (DW+1)'(ar1_q) - (DW+1)'(br1_q);
        si_q <= (DW+1)'(ai1_q) - (DW+1)'(bi1_q);
      end else begin
        sr_q <= (DW+1)'(ar1_q) + (DW+1)'(br1_q);
        si_q <= (DW+1)'(ai1_q) + (DW+1)'(bi1_q);
      end
    end
  end

  // finishing logic that feeds the first divider cell
  always_comb begin
    logic signed [PW:0]   shr, shi;
    logic signed [DW-1:0] rr, ri;
    logic                 ovr, ovi;
    side_o = '0;
    shr = mr_q >>> FRAC_BITS;
    shi = mi_q >>> FRAC_BITS;
    rr  = '0;
    ri  = '0;
    ovr = 1'b0;
    ovi = 1'b0;
    unique case (k2_q) inside
      KIND_ADD, KIND_SUB: begin
        ovr = (sr_q[DW] != sr_q[DW-1]);
        ovi = (si_q[DW] != si_q[DW-1]);
        rr  = ovr ? (sr_q[DW] ? MIN_D : MAX_D) : sr_q[DW-1:0];
        ri  = ovi ? (si_q[DW] ? MIN_D : MAX_D) : si_q[DW-1:0];
      end
      KIND_MUL: begin
        ovr = (shr > MAX_W) || (shr < MIN_W);
        ovi = (shi > MAX_W) || (shi < MIN_W);
        rr  = (shr > MAX_W) ? MAX_D : ((shr < MIN_W) ? MIN_D : shr[DW-1:0]);
        ri  = (shi > MAX_W) ? MAX_D : ((shi < MIN_W) ? MIN_D : shi[DW-1:0]);
      end
      KIND_DIV: begin
        side_o.is_div         = (mb_q != '0);
        side_o.divide_by_zero = (mb_q == '0);
      end
      KIND_EQ: side_o.test_true = eq_q;
      KIND_NE: side_o.test_true = ~eq_q;
      KIND_GT: side_o.test_true = (ma_q > mb_q);
      KIND_LE: side_o.test_true = ~(ma_q > mb_q);
      KIND_LT: side_o.test_true = (ma_q < mb_q);
      KIND_GE: side_o.test_true = ~(ma_q < mb_q);
      default: ;
    endcase
    side_o.res_real = 32'(rr);
    side_o.res_imag = 32'(ri);
    side_o.overflow = ovr | ovi;
  end

  assign valid_o  = v2_q;
  assign den_o    = mb_q;
  assign neg_o[0] = dr_q[PW];
  assign neg_o[1] = di_q[PW];
  assign num_o[0] = dr_q[PW] ? PW'(-dr_q) : dr_q[PW-1:0];
  assign num_o[1] = di_q[PW] ? PW'(-di_q) : di_q[PW-1:0];

endmodule

@@ sv/complex_number_alu.sv @@
// Top level of the complex number ALU: front pipeline, divider chain, output word.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------------
//  in      | in_valid_i / in_ready_o | kind_i, a_real_i, a_imag_i, b_real_i, b_imag_i
//  out     | out_valid_o/out_ready_i | res_real_o, res_imag_o, test_true_o,
//          |                         | overflow_o, divide_by_zero_o
//
// One word per cycle while the output is not stalled. A word accepted at the
// input passes through the front pipeline, the divider chain (one cell per
// quotient bit) and the output register.
// Reset clears only the valid bits of every stage.
// A stall at the output freezes the whole pipe; an empty input stage still
// takes a word while the pipe is frozen.
module complex_number_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] a_real_i,
  input  logic signed [31:0] a_imag_i,
  input  logic signed [31:0] b_real_i,
  input  logic signed [31:0] b_imag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_real_o,
  output logic signed [31:0] res_imag_o,
  output logic               test_true_o,
  output logic               overflow_o,
  output logic               divide_by_zero_o
);
  import cna_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  // quotient bits: numerator bits plus the fraction shift
  localparam int NC = PW + FRAC_BITS;
  localparam logic signed [DW-1:0] MAX_D = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_D = {1'b1, {(DW-1){1'b0}}};

  logic adv;   // whole pipe moves

  logic                       out_v_q;
  side_t                      out_q;

  assign adv = ~out_v_q | out_ready_i;

  // chain taps, index 0 is the front end
  logic [NC:0]                vld_w;
  side_t                      side_w [NC+1];
  logic [PW-1:0]              den_w  [NC+1];
  logic [1:0][PW-1:0]         num_w  [NC+1];
  logic [1:0]                 neg_w  [NC+1];
  logic [1:0][PW-1:0]         rem_w  [NC+1];
  logic [1:0][DW-1:0]         quo_w  [NC+1];
  logic [1:0]                 stk_w  [NC+1];

  cna_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i    (kind_i),
    .a_real_i  (a_real_i),
    .a_imag_i  (a_imag_i),
    .b_real_i  (b_real_i),
    .b_imag_i  (b_imag_i),
    .valid_o   (vld_w[0]),
    .side_o    (side_w[0]),
    .den_o     (den_w[0]),
    .num_o     (num_w[0]),
    .neg_o     (neg_w[0])
  );

  assign rem_w[0] = '0;
  assign quo_w[0] = '0;
  assign stk_w[0] = '0;

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < NC; k++) begin : g_cell
    cna_div_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .BIT_IDX   (NC - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(vld_w[k]),
      .side_i (side_w[k]),
      .den_i  (den_w[k]),
      .num_i  (num_w[k]),
      .neg_i  (neg_w[k]),
      .rem_i  (rem_w[k]),
      .quo_i  (quo_w[k]),
      .stk_i  (stk_w[k]),
      .valid_o(vld_w[k+1]),
      .side_o (side_w[k+1]),
      .den_o  (den_w[k+1]),
      .num_o  (num_w[k+1]),
      .neg_o  (neg_w[k+1]),
      .rem_o  (rem_w[k+1]),
      .quo_o  (quo_w[k+1]),
      .stk_o  (stk_w[k+1])
    );
  end

  // quotient saturation; stk marks quotient bits above the kept window
  side_t fin_d;

  always_comb begin
    logic [1:0]                 ovf;
    logic signed [1:0][DW-1:0]  val;
    logic [DW-1:0]              q;
    logic                       big;
    fin_d = side_w[NC];
    ovf   = '0;
    val   = '0;
    for (int l = 0; l < 2; l++) begin
      q   = quo_w[NC][l];
      big = stk_w[NC][l];
      if (!neg_w[NC][l]) begin
        ovf[l] = big | q[DW-1];
        val[l] = ovf[l] ? MAX_D : q;
      end else begin
        ovf[l] = big | (q[DW-1] & (|q[DW-2:0]));
        val[l] = ovf[l] ? MIN_D : (-q);
      end
    end
    if (side_w[NC].is_div) begin
      fin_d.res_real = 32'($signed(val[0]));
      fin_d.res_imag = 32'($signed(val[1]));
      fin_d.overflow = |ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vld_w[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= fin_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign res_real_o       = out_q.res_real;
  assign res_imag_o       = out_q.res_imag;
  assign test_true_o      = out_q.test_true;
  assign overflow_o       = out_q.overflow;
  assign divide_by_zero_o = out_q.divide_by_zero;

endmodule
